// ===== design/wmmb_pkg.sv =====
// Shared constants and types for the waveform min/max bucketer.
`timescale 1ns / 1ps
`default_nettype none

package wmmb_pkg;

  localparam int PEAK_BUCKETS  = 128;
  localparam int MAX_CHANNELS  = 8;
  localparam int FRAME_W       = 24;
  localparam int SAMPLE_W      = 24;
  localparam int MAXV_W        = 23;
  localparam int IDX_W         = 7;
  localparam int NCH_W         = 4;
  localparam int BUCKET_W      = $clog2(PEAK_BUCKETS + 1);
  localparam int CH_W          = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 24;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int SETTLE_CYCLES = 3;
  localparam int SETTLE_W      = $clog2(SETTLE_CYCLES + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOTAL_FRAMES = 2'd0,
    CFG_NUM_CHANNELS = 2'd1,
    CFG_TRIM_START   = 2'd2,
    CFG_TRIM_END     = 2'd3
  } cfg_reg_t;

  // Window geometry derived from the configuration registers.
  typedef struct packed {
    logic [FRAME_W-1:0]  total;
    logic [FRAME_W-1:0]  start;
    logic [FRAME_W-1:0]  end_f;
    logic [FRAME_W-1:0]  usable;
    logic [FRAME_W-1:0]  step;
    logic [BUCKET_W-1:0] nb;
    logic [NCH_W-1:0]    nch;
    logic                settled;
  } window_t;

  // One classified sample on its way to the back end.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       first;
    logic                       last_ch;
  } work_t;

endpackage

`default_nettype wire

// ===== design/wmmb_cfg.sv =====
// Configuration registers and the pipelined window clamp.
`timescale 1ns / 1ps
`default_nettype none

module wmmb_cfg import wmmb_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output window_t                    win
);

  logic [FRAME_W-1:0]  total_frames;
  logic [NCH_W-1:0]    num_channels;
  logic [FRAME_W-1:0]  trim_start;
  logic [FRAME_W-1:0]  trim_end;
  logic [SETTLE_W-1:0] settle;
  logic [SETTLE_W-1:0] settle_next;

  logic [FRAME_W-1:0]  start_s1;
  logic [FRAME_W-1:0]  endsel_s1;
  logic [NCH_W-1:0]    nch_s1;
  logic [FRAME_W-1:0]  start_s2;
  logic [FRAME_W-1:0]  end_s2;
  logic [FRAME_W-1:0]  usable_s2;
  logic [BUCKET_W-1:0] nb_s3;
  logic [FRAME_W-1:0]  step_s3;

  logic [FRAME_W:0]    lo_c;
  logic [FRAME_W:0]    endlo_c;
  logic [FRAME_W-1:0]  end_c;
  logic [BUCKET_W-1:0] nb_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_frames <= '0;
      num_channels <= NCH_W'(1);
      trim_start   <= '0;
      trim_end     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_TOTAL_FRAMES: total_frames <= cfg_data[FRAME_W-1:0];
        CFG_NUM_CHANNELS: num_channels <= cfg_data[NCH_W-1:0];
        CFG_TRIM_START:   trim_start   <= cfg_data[FRAME_W-1:0];
        CFG_TRIM_END:     trim_end     <= cfg_data[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold off new samples until the clamp pipeline has seen the last write.
  always_comb begin
    if (cfg_we) begin
      settle_next = SETTLE_W'(SETTLE_CYCLES);
    end else if (settle != '0) begin
      settle_next = settle - SETTLE_W'(1);
    end else begin
      settle_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= SETTLE_W'(SETTLE_CYCLES);
    end else begin
      settle <= settle_next;
    end
  end

  always_comb begin
    lo_c    = {1'b0, start_s1} + (FRAME_W+1)'(1);
    endlo_c = ({1'b0, endsel_s1} < lo_c) ? lo_c : {1'b0, endsel_s1};
    end_c   = (endlo_c > {1'b0, total_frames}) ? total_frames : endlo_c[FRAME_W-1:0];
    nb_c    = (usable_s2 < FRAME_W'(PEAK_BUCKETS)) ? usable_s2[BUCKET_W-1:0]
                                                    : BUCKET_W'(PEAK_BUCKETS);
  end

  always_ff @(posedge clk) begin
    start_s1  <= (trim_start < total_frames) ? trim_start : total_frames - FRAME_W'(1);
    endsel_s1 <= (trim_end > trim_start) ? trim_end : total_frames;
    if (num_channels == '0) begin
      nch_s1 <= NCH_W'(1);
    end else if (num_channels > NCH_W'(MAX_CHANNELS)) begin
      nch_s1 <= NCH_W'(MAX_CHANNELS);
    end else begin
      nch_s1 <= num_channels;
    end
    start_s2  <= start_s1;
    end_s2    <= end_c;
    usable_s2 <= end_c - start_s1;
    nb_s3     <= nb_c;
    step_s3   <= usable_s2 - {{(FRAME_W-BUCKET_W){1'b0}}, nb_c};
  end

  always_comb begin
    win.total   = total_frames;
    win.start   = start_s2;
    win.end_f   = end_s2;
    win.usable  = usable_s2;
    win.step    = step_s3;
    win.nb      = nb_s3;
    win.nch     = nch_s1;
    win.settled = (settle == '0);
  end

endmodule

`default_nettype wire

// ===== design/wmmb_front.sv =====
// Front end: accepts samples, tracks channel and frame, classifies against the window.
`timescale 1ns / 1ps
`default_nettype none

module wmmb_front import wmmb_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire window_t                    win,
  input  wire logic                       in_valid,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  input  wire logic                       queue_full,
  output logic                            in_ready,
  output logic                            push,
  output work_t                           push_data
);

  logic [FRAME_W-1:0] frame_count;
  logic [CH_W-1:0]    channel_count;
  logic               take;
  logic               active;
  logic               in_win;
  logic               last_ch;

  always_comb begin
    in_ready  = win.settled && !queue_full;
    take      = in_valid && in_ready;
    active    = (win.total != '0);
    in_win    = (frame_count >= win.start) && (frame_count < win.end_f);
    last_ch   = (NCH_W'(channel_count) + NCH_W'(1)) >= win.nch;
    push      = take && active && in_win;
    push_data.sample  = sample;
    push_data.first   = (frame_count == win.start) && (channel_count == '0);
    push_data.last_ch = last_ch;
  end

  // Samples of an empty buffer are dropped and leave the counters alone.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count   <= '0;
      channel_count <= '0;
    end else if (take && active) begin
      if (last_ch) begin
        channel_count <= '0;
        if (({1'b0, frame_count} + (FRAME_W+1)'(1)) >= {1'b0, win.total}) begin
          frame_count <= '0;
        end else begin
          frame_count <= frame_count + FRAME_W'(1);
        end
      end else begin
        channel_count <= channel_count + CH_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/wmmb_queue.sv =====
// Short queue that decouples the front end from the bucket back end.
`timescale 1ns / 1ps
`default_nettype none

module wmmb_queue import wmmb_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire work_t push_data,
  input  wire logic  pop,
  output logic       full,
  output logic       q_valid,
  output work_t      q_data
);

  work_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  always_comb begin
    full    = (count == QCNT_W'(QUEUE_DEPTH));
    q_valid = (count != '0);
    q_data  = slots[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/wmmb_back.sv =====
// Back end: running extremes, bucket boundary accumulator and the output register.
`timescale 1ns / 1ps
`default_nettype none

module wmmb_back import wmmb_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire window_t                 win,
  input  wire logic                    q_valid,
  input  wire work_t                   q_data,
  input  wire logic                    out_ready,
  output logic                         pop,
  output logic                         out_valid,
  output logic signed [SAMPLE_W-1:0]   min_value,
  output logic [MAXV_W-1:0]            max_value,
  output logic [IDX_W-1:0]             bucket_index,
  output logic                         last_bucket
);

  logic [BUCKET_W-1:0]        bucket_count;
  logic [FRAME_W-1:0]         boundary_remainder;
  logic signed [SAMPLE_W-1:0] running_min;
  logic signed [SAMPLE_W-1:0] running_max;

  logic [BUCKET_W-1:0]        bc_base;
  logic [FRAME_W-1:0]         br_base;
  logic signed [SAMPLE_W-1:0] min_base;
  logic signed [SAMPLE_W-1:0] max_base;
  logic signed [SAMPLE_W-1:0] min_new;
  logic signed [SAMPLE_W-1:0] max_new;
  logic [FRAME_W-1:0]         nb_ext;
  logic                       emit;
  logic                       is_last;

  always_comb begin
    pop    = q_valid && (!out_valid || out_ready);
    nb_ext = {{(FRAME_W-BUCKET_W){1'b0}}, win.nb};
    // Reload at the first sample of the window.
    if (q_data.first) begin
      bc_base  = '0;
      br_base  = win.step;
      min_base = '0;
      max_base = '0;
    end else begin
      bc_base  = bucket_count;
      br_base  = boundary_remainder;
      min_base = running_min;
      max_base = running_max;
    end
    min_new = (q_data.sample < min_base) ? q_data.sample : min_base;
    max_new = (q_data.sample > max_base) ? q_data.sample : max_base;
    emit    = q_data.last_ch && (br_base < nb_ext);
    is_last = (bc_base + BUCKET_W'(1)) >= win.nb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count       <= '0;
      boundary_remainder <= '0;
      running_min        <= '0;
      running_max        <= '0;
    end else if (pop) begin
      if (emit) begin
        bucket_count       <= is_last ? bc_base : bc_base + BUCKET_W'(1);
        boundary_remainder <= br_base + win.step;
        running_min        <= '0;
        running_max        <= '0;
      end else begin
        bucket_count       <= bc_base;
        boundary_remainder <= q_data.last_ch ? br_base - nb_ext : br_base;
        running_min        <= min_new;
        running_max        <= max_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      min_value    <= min_new;
      max_value    <= max_new[MAXV_W-1:0];
      bucket_index <= bc_base[IDX_W-1:0];
      last_bucket  <= is_last;
    end
  end

endmodule

`default_nettype wire

// ===== design/waveform_min_max_bucketer_top.sv =====
// Top level of the waveform min/max bucketer.
//
// Input: one signed Q1.23 sample per transaction on in_valid/in_ready, channels
// interleaved frame by frame. Output: one transaction per bucket on
// out_valid/out_ready carrying the bucket minimum and maximum over all
// channels (both seeded at zero), the bucket index and a final-bucket flag.
// Samples outside the trim window and all samples of an empty buffer are
// consumed without effect.
// Throughput is one sample per cycle while in_ready is high. After the bucket's
// last sample is taken, its result passes through the front queue and then the
// output register. The back end's combinational min/max and accumulator update
// sets that rate.
// Configuration goes through cfg_we/cfg_index/cfg_data while the block is idle;
// in_ready drops after each write while the window clamp pipeline recomputes,
// and after reset.
// When out_ready is low the output register holds; the four-entry queue keeps
// taking samples until it fills, then in_ready drops.
// Reset is synchronous and active high and clears counters, extremes and queue.
`timescale 1ns / 1ps
`default_nettype none

module waveform_min_max_bucketer_top import wmmb_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [SAMPLE_W-1:0]      min_value,
  output logic [MAXV_W-1:0]               max_value,
  output logic [IDX_W-1:0]                bucket_index,
  output logic                            last_bucket
);

  window_t win;
  work_t   push_data;
  work_t   q_data;
  logic    push;
  logic    pop;
  logic    queue_full;
  logic    q_valid;

  wmmb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .win       (win)
  );

  wmmb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .win        (win),
    .in_valid   (in_valid),
    .sample     (sample),
    .queue_full (queue_full),
    .in_ready   (in_ready),
    .push       (push),
    .push_data  (push_data)
  );

  wmmb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (queue_full),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  wmmb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .win          (win),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .out_ready    (out_ready),
    .pop          (pop),
    .out_valid    (out_valid),
    .min_value    (min_value),
    .max_value    (max_value),
    .bucket_index (bucket_index),
    .last_bucket  (last_bucket)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !queue_full)
    else $error("queue written while full");

  a_empty_drops: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (win.total == '0)) |-> !push)
    else $error("sample of empty buffer reached the back end");

  a_extremes_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (min_value <= 0))
    else $error("bucket minimum above zero");
`endif

endmodule

`default_nettype wire
